// ----- rtl/crc64s_pkg.sv -----
// Package for the CRC-64/ECMA power-of-x shifter.
// Holds the polynomial constants, the one-step fold function and the power tables.
// No dependencies.
package crc64s_pkg;

  localparam logic [63:0] CRC_POLY  = 64'hC96C5795D7870F42;
  localparam logic [63:0] X_INVERSE = 64'h92D8AF2BAF0E1E85;
  localparam logic [63:0] X_ONE     = 64'h1 << 62;
  localparam logic [63:0] ONE_VALUE = 64'h1 << 63;

  localparam int unsigned TAB_DEPTH = 64;
  localparam int unsigned TAB_IDX_W = 6;
  localparam int unsigned STEP_W    = 6;

  typedef logic [63:0] pow_tab_t [TAB_DEPTH];

  // Controls from the sequencer to the serial multiplier.
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  // Status from the serial multiplier back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // One step of the reflected carry-less multiply: fold the low bit of the
  // accumulator back in through the polynomial and add the multiplicand
  // when the current multiplier bit is set.
  function automatic logic [63:0] gf_step(input logic [63:0] acc,
                                          input logic        rbit,
                                          input logic [63:0] lhs);
    logic [63:0] fold;
    logic [63:0] add;
    fold = acc[0] ? CRC_POLY : 64'h0;
    add  = rbit ? lhs : 64'h0;
    return (acc >> 1) ^ fold ^ add;
  endfunction

  function automatic logic [63:0] gf_mul(input logic [63:0] lhs,
                                         input logic [63:0] rhs);
    logic [63:0] acc;
    logic [63:0] r;
    acc = 64'h0;
    r   = rhs;
    for (int s = 0; s < 64; s++) begin
      acc = gf_step(acc, r[0], lhs);
      r   = r >> 1;
    end
    return acc;
  endfunction

  // Entry i holds seed^(2^i): each entry is the square of the one before.
  function automatic pow_tab_t build_table(input logic [63:0] seed);
    pow_tab_t    tab;
    logic [63:0] p;
    p = seed;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      tab[k] = p;
      p      = gf_mul(p, p);
    end
    return tab;
  endfunction

  localparam pow_tab_t FWD_TABLE = build_table(X_ONE);
  localparam pow_tab_t INV_TABLE = build_table(X_INVERSE);

endpackage

// ----- rtl/crc64s_mul.sv -----
// Bit-serial carry-less multiplier modulo the reflected CRC-64/ECMA polynomial.
// One multiplier bit per cycle; a new product is taken only while the multiplier is not busy.
// Depends on crc64s_pkg.
module crc64s_mul
  import crc64s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mul_ctrl_t   ctrl,
  input  logic [63:0] lhs,
  input  logic [63:0] rhs,
  output mul_stat_t   stat,
  output logic [63:0] product
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       lhs_r, lhs_nxt;
  logic [63:0]       rhs_r, rhs_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    lhs_nxt  = lhs_r;
    rhs_nxt  = rhs_r;
    if (ctrl.start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      acc_nxt  = 64'h0;
      lhs_nxt  = lhs;
      rhs_nxt  = rhs;
    end else if (busy_r) begin
      acc_nxt  = gf_step(acc_r, rhs_r[0], lhs_r);
      rhs_nxt  = rhs_r >> 1;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == {STEP_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
    lhs_r <= lhs_nxt;
    rhs_r <= rhs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !busy_r)
    else $error("multiplier started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done raised while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> busy_r && step_r == '0)
    else $error("multiplier did not begin after start");

endmodule

// ----- rtl/crc64_shift_by_power_of_x_top.sv -----
// Top level of the CRC-64/ECMA power-of-x shifter: sequencer, power tables, output register.
// Depends on crc64s_pkg and crc64s_mul.
//
//   channel  direction  ports                                             handshake
//   input    in         in_operand_value, in_shift_count, in_direction    in_valid / in_stall
//   result   out        out_shifted_value                                 out_valid / out_stall
//
// One word is taken at a time. The sequencer walks the count bits from the
// lowest up, one per cycle while the bits are clear, and runs a bit-serial
// multiply for each set bit, which holds the walk until the product is done.
// Reset clears all control state; the tables are constants and need no fill.
// A finished result waits in the output register while the next word is
// taken; out_stall only holds back the end of the following word.
module crc64_shift_by_power_of_x_top
  import crc64s_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_operand_value,
  input  logic [63:0] in_shift_count,
  input  logic        in_direction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_shifted_value
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MUL, S_FINISH} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [63:0]      count_r, count_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic             dir_r, dir_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_value_r, out_value_nxt;

  mul_ctrl_t        mul_ctrl;
  mul_stat_t        mul_stat;
  logic [63:0]      mul_product;
  logic [63:0]      power;
  logic [TAB_IDX_W-1:0] tab_idx;
  logic             last_bit;
  logic             out_free;

  // Table position for the current count bit; the selected power feeds the
  // multiplier, which latches it on start.
  assign tab_idx  = TAB_IDX_W'(idx_r);
  assign power    = dir_r ? INV_TABLE[tab_idx] : FWD_TABLE[tab_idx];
  assign last_bit = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign out_free = !out_valid_r || !out_stall;

  crc64s_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mul_ctrl),
    .lhs     (prod_r),
    .rhs     (power),
    .stat    (mul_stat),
    .product (mul_product)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    prod_nxt       = prod_r;
    dir_nxt        = dir_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    mul_ctrl.start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          prod_nxt  = in_operand_value;
          count_nxt = in_shift_count;
          dir_nxt   = in_direction;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (count_r[0]) begin
          mul_ctrl.start = 1'b1;
          state_nxt      = S_MUL;
        end else if (last_bit) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          count_nxt = count_r >> 1;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          prod_nxt = mul_product;
          if (last_bit) begin
            state_nxt = S_FINISH;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            count_nxt = count_r >> 1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = prod_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    count_r     <= count_nxt;
    prod_r      <= prod_nxt;
    dir_r       <= dir_nxt;
    out_value_r <= out_value_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_shifted_value = out_value_r;

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> state_r == S_MUL)
    else $error("multiplier finished outside of a multiply");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_SCAN && idx_r == '0)
    else $error("accepted word did not start the scan");

  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && !mul_stat.done) |-> mul_stat.busy)
    else $error("waiting on a multiplier that is not running");

endmodule
